### hw/rtl/assert_macros.svh
// Assertion helpers; every user has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

### hw/rtl/i2crs_pkg.sv
package i2crs_pkg;

  localparam int MaxRes = 4;
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // input modes
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeScan  = 2'd2;
  localparam logic [1:0] ModeResp  = 2'd3;

  // result ops
  localparam logic [2:0] OpStart = 3'd0;
  localparam logic [2:0] OpStop  = 3'd1;
  localparam logic [2:0] OpSend  = 3'd2;
  localparam logic [2:0] OpRecv  = 3'd3;
  localparam logic [2:0] OpOut   = 3'd4;
  localparam logic [2:0] OpDone  = 3'd5;

  // done status
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNack = 2'd1;
  localparam logic [1:0] StNone = 2'd2;

  // sequencer phases
  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhHdr   = 3'd1;
  localparam logic [2:0] PhWdata = 3'd2;
  localparam logic [2:0] PhRaddr = 3'd3;
  localparam logic [2:0] PhRecv  = 3'd4;
  localparam logic [2:0] PhScan  = 3'd5;

  localparam logic [7:0] DummyByte = 8'hFF;
  localparam logic [6:0] LastProbe = 7'd127;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] bus_byte;
    logic       master_ack;
    logic [1:0] status;
    logic [6:0] found_addr;
  } res_t;

  // all results of one input item, slot 0 first
  typedef struct packed {
    logic [2:0]              cnt;
    res_t [MaxRes-1:0]       res;
  } bundle_t;

  function automatic res_t mk_res(input logic [2:0] op, input logic [7:0] b,
                                  input logic ack, input logic [1:0] st,
                                  input logic [6:0] fa);
    res_t r;
    r.op         = op;
    r.bus_byte   = b;
    r.master_ack = ack;
    r.status     = st;
    r.found_addr = fa;
    return r;
  endfunction

endpackage

### hw/rtl/i2crs_front.sv
module i2crs_front
  import i2crs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [1:0]    in_mode,
  input  logic [6:0]    in_dev_addr,
  input  logic [15:0]   in_reg_addr,
  input  logic [1:0]    in_reg_len,
  input  logic [7:0]    in_data_len,
  input  logic          in_nack,
  input  logic [7:0]    in_rx_byte,
  input  logic [7:0]    in_payload,
  input  logic          q_full,
  output logic          q_push,
  output bundle_t       q_bundle
);

  logic [2:0]  phase_r, phase_nxt;
  logic        is_read_r, is_read_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [15:0] reg_r, reg_nxt;
  logic [1:0]  rbl_r, rbl_nxt;
  logic [7:0]  dbl_r, dbl_nxt;
  logic [6:0]  probe_r, probe_nxt;
  logic        acc;
  logic [7:0]  dec;
  logic [6:0]  probe_inc;
  bundle_t     bnd;

  assign acc       = in_push && !q_full;
  assign dec       = (dbl_r != 8'd0) ? dbl_r - 8'd1 : dbl_r;
  assign probe_inc = probe_r + 7'd1;

  always_comb begin
    phase_nxt   = phase_r;
    is_read_nxt = is_read_r;
    dev_nxt     = dev_r;
    reg_nxt     = reg_r;
    rbl_nxt     = rbl_r;
    dbl_nxt     = dbl_r;
    probe_nxt   = probe_r;
    bnd         = '0;
    if (acc) begin
      if (in_mode != ModeResp) begin
        // commands are dropped while a transaction runs
        if (phase_r == PhIdle) begin
          if (in_mode == ModeScan) begin
            probe_nxt  = 7'd1;
            bnd.cnt    = 3'd2;
            bnd.res[0] = mk_res(OpStart, 8'h00, 1'b0, StOk, 7'd0);
            bnd.res[1] = mk_res(OpSend, {7'd1, 1'b0}, 1'b0, StOk, 7'd0);
            phase_nxt  = PhScan;
          end else begin
            is_read_nxt = (in_mode == ModeRead);
            dev_nxt     = in_dev_addr;
            reg_nxt     = in_reg_addr;
            rbl_nxt     = (in_reg_len == 2'd2) ? 2'd2 :
                          ((in_reg_len != 2'd0) ? 2'd1 : 2'd0);
            dbl_nxt     = in_data_len;
            if (in_mode == ModeRead && in_data_len == 8'd0) begin
              bnd.cnt    = 3'd1;
              bnd.res[0] = mk_res(OpDone, 8'h00, 1'b0, StOk, 7'd0);
            end else begin
              bnd.cnt    = 3'd2;
              bnd.res[0] = mk_res(OpStart, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[1] = mk_res(OpSend, {in_dev_addr, 1'b0}, 1'b0, StOk, 7'd0);
              phase_nxt  = PhHdr;
            end
          end
        end
      end else begin
        case (phase_r)
          PhHdr: begin
            if (in_nack) begin
              bnd.cnt    = 3'd2;
              bnd.res[0] = mk_res(OpStop, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[1] = mk_res(OpDone, 8'h00, 1'b0, StNack, 7'd0);
              phase_nxt  = PhIdle;
            end else if (rbl_r == 2'd2) begin
              bnd.cnt    = 3'd1;
              bnd.res[0] = mk_res(OpSend, reg_r[15:8], 1'b0, StOk, 7'd0);
              rbl_nxt    = 2'd1;
            end else if (rbl_r == 2'd1) begin
              bnd.cnt    = 3'd1;
              bnd.res[0] = mk_res(OpSend, reg_r[7:0], 1'b0, StOk, 7'd0);
              rbl_nxt    = 2'd0;
            end else if (is_read_r) begin
              // repeated start, address with read bit
              bnd.cnt    = 3'd2;
              bnd.res[0] = mk_res(OpStart, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[1] = mk_res(OpSend, {dev_r, 1'b1}, 1'b0, StOk, 7'd0);
              phase_nxt  = PhRaddr;
            end else if (dbl_r == 8'd0) begin
              bnd.cnt    = 3'd2;
              bnd.res[0] = mk_res(OpStop, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[1] = mk_res(OpDone, 8'h00, 1'b0, StOk, 7'd0);
              phase_nxt  = PhIdle;
            end else begin
              bnd.cnt    = 3'd1;
              bnd.res[0] = mk_res(OpSend, in_payload, 1'b0, StOk, 7'd0);
              dbl_nxt    = dbl_r - 8'd1;
              phase_nxt  = PhWdata;
            end
          end
          PhWdata: begin
            if (in_nack || dbl_r == 8'd0) begin
              bnd.cnt    = 3'd2;
              bnd.res[0] = mk_res(OpStop, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[1] = mk_res(OpDone, 8'h00, 1'b0, in_nack ? StNack : StOk, 7'd0);
              phase_nxt  = PhIdle;
            end else begin
              bnd.cnt    = 3'd1;
              bnd.res[0] = mk_res(OpSend, in_payload, 1'b0, StOk, 7'd0);
              dbl_nxt    = dbl_r - 8'd1;
            end
          end
          PhRaddr: begin
            if (in_nack) begin
              bnd.cnt    = 3'd2;
              bnd.res[0] = mk_res(OpStop, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[1] = mk_res(OpDone, 8'h00, 1'b0, StNack, 7'd0);
              phase_nxt  = PhIdle;
            end else begin
              bnd.cnt    = 3'd1;
              bnd.res[0] = mk_res(OpRecv, DummyByte, dbl_r > 8'd1, StOk, 7'd0);
              phase_nxt  = PhRecv;
            end
          end
          PhRecv: begin
            // a NACK here is ignored; the byte is delivered anyway
            bnd.res[0] = mk_res(OpOut, in_rx_byte, 1'b0, StOk, 7'd0);
            dbl_nxt    = dec;
            if (dec == 8'd0) begin
              bnd.cnt    = 3'd3;
              bnd.res[1] = mk_res(OpStop, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[2] = mk_res(OpDone, 8'h00, 1'b0, StOk, 7'd0);
              phase_nxt  = PhIdle;
            end else begin
              bnd.cnt    = 3'd2;
              bnd.res[1] = mk_res(OpRecv, DummyByte, dec > 8'd1, StOk, 7'd0);
            end
          end
          PhScan: begin
            bnd.res[0] = mk_res(OpStop, 8'h00, 1'b0, StOk, 7'd0);
            if (!in_nack) begin
              bnd.cnt    = 3'd2;
              bnd.res[1] = mk_res(OpDone, 8'h00, 1'b0, StOk, probe_r);
              phase_nxt  = PhIdle;
            end else if (probe_r == LastProbe) begin
              bnd.cnt    = 3'd2;
              bnd.res[1] = mk_res(OpDone, 8'h00, 1'b0, StNone, 7'd0);
              phase_nxt  = PhIdle;
            end else begin
              bnd.cnt    = 3'd3;
              bnd.res[1] = mk_res(OpStart, 8'h00, 1'b0, StOk, 7'd0);
              bnd.res[2] = mk_res(OpSend, {probe_inc, 1'b0}, 1'b0, StOk, 7'd0);
              probe_nxt  = probe_inc;
            end
          end
          default: begin
            phase_nxt = PhIdle;
          end
        endcase
      end
    end
  end

  assign q_push   = acc && (bnd.cnt != 3'd0);
  assign q_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PhIdle;
      is_read_r <= 1'b0;
      dev_r     <= 7'd0;
      reg_r     <= 16'd0;
      rbl_r     <= 2'd0;
      dbl_r     <= 8'd0;
      probe_r   <= 7'd0;
    end else begin
      phase_r   <= phase_nxt;
      is_read_r <= is_read_nxt;
      dev_r     <= dev_nxt;
      reg_r     <= reg_nxt;
      rbl_r     <= rbl_nxt;
      dbl_r     <= dbl_nxt;
      probe_r   <= probe_nxt;
    end
  end

`include "assert_macros.svh"

  `CHK_NEXT(a_cmd_busy_kept, (acc && in_mode != ModeResp && phase_r != PhIdle), (phase_r == $past(phase_r)), "command while busy changed phase")
  `CHK_ALWAYS(a_push_gated, (q_push |-> !q_full), "push into a full queue")

endmodule

### hw/rtl/i2crs_queue.sv
module i2crs_queue
  import i2crs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    rd_en,
  output bundle_t rd_data,
  output logic    empty
);

  bundle_t        mem_r [QDepth];
  logic [QAw-1:0] wptr_r, wptr_nxt;
  logic [QAw-1:0] rptr_r, rptr_nxt;
  logic [QAw:0]   count_r, count_nxt;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count_r == QAw'(0) + (QAw+1)'(QDepth));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_wr ? wptr_r + QAw'(1) : wptr_r;
    rptr_nxt  = do_rd ? rptr_r + QAw'(1) : rptr_r;
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (QAw+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

`include "assert_macros.svh"

  `CHK_ALWAYS(a_count_range, (count_r <= (QAw+1)'(QDepth)), "queue count out of range")
  `CHK_ALWAYS(a_ptr_match, ((wptr_r - rptr_r) == count_r[QAw-1:0]), "queue pointers disagree with count")

endmodule

### hw/rtl/i2crs_back.sv
module i2crs_back
  import i2crs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_op,
  output logic [7:0] out_bus_byte,
  output logic       out_master_ack,
  output logic [1:0] out_status,
  output logic [6:0] out_found_addr,
  output logic       out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       take;
  res_t       cur;

  assign empty = q_empty;
  assign take  = pop && !q_empty;
  assign cur   = head.res[idx_r];

  assign out_op         = cur.op;
  assign out_bus_byte   = cur.bus_byte;
  assign out_master_ack = cur.master_ack;
  assign out_status     = cur.status;
  assign out_found_addr = cur.found_addr;
  assign out_last       = ({1'b0, idx_r} == head.cnt - 3'd1);

  // bundle leaves the queue with its final beat
  assign q_pop   = take && out_last;
  assign idx_nxt = take ? (out_last ? 2'd0 : idx_r + 2'd1) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

`include "assert_macros.svh"

  `CHK_ALWAYS(a_head_nonempty, (!q_empty |-> (head.cnt != 3'd0)), "empty bundle in queue")
  `CHK_ALWAYS(a_idx_in_bundle, (!q_empty |-> (3'(idx_r) < head.cnt)), "slot index past bundle")

endmodule

### hw/rtl/i2c_register_transaction_sequencer_top.sv
// Channel   Handshake          Ports
// input     push / full        in_mode .. in_payload
// result    empty / pop        out_op .. out_last
//
// One input item is taken per cycle while the bundle queue has room.
// Each item's 0..3 results are decided in the cycle it is taken and leave
// one beat per cycle; the result side sets the pace for busy items.
// Results appear on the ports once every earlier bundle has left the queue.
// Reset clears the sequencer state, the queue and the slot index.
// full rises when the bundle queue (four entries) is full.
module i2c_register_transaction_sequencer_top
  import i2crs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [6:0]  in_dev_addr,
  input  logic [15:0] in_reg_addr,
  input  logic [1:0]  in_reg_len,
  input  logic [7:0]  in_data_len,
  input  logic        in_nack,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_payload,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_op,
  output logic [7:0]  out_bus_byte,
  output logic        out_master_ack,
  output logic [1:0]  out_status,
  output logic [6:0]  out_found_addr,
  output logic        out_last
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wdata;
  bundle_t q_rdata;

  assign full = q_full;

  i2crs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (push),
    .in_mode     (in_mode),
    .in_dev_addr (in_dev_addr),
    .in_reg_addr (in_reg_addr),
    .in_reg_len  (in_reg_len),
    .in_data_len (in_data_len),
    .in_nack     (in_nack),
    .in_rx_byte  (in_rx_byte),
    .in_payload  (in_payload),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_bundle    (q_wdata)
  );

  i2crs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  i2crs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_op         (out_op),
    .out_bus_byte   (out_bus_byte),
    .out_master_ack (out_master_ack),
    .out_status     (out_status),
    .out_found_addr (out_found_addr),
    .out_last       (out_last)
  );

endmodule

### sim/i2c_sequencer_checker.sv
module i2c_sequencer_checker
  import i2crs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_mode,
  input  logic [6:0]  in_dev_addr,
  input  logic [15:0] in_reg_addr,
  input  logic [1:0]  in_reg_len,
  input  logic [7:0]  in_data_len,
  input  logic        in_nack,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_payload,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  out_op,
  input  logic [7:0]  out_bus_byte,
  input  logic        out_master_ack,
  input  logic [1:0]  out_status,
  input  logic [6:0]  out_found_addr,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output logic        busy,
  output int          items_taken,
  output int          beats_checked,
  output int          done_ok,
  output int          done_nack,
  output int          done_none
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] bus_byte;
    logic       master_ack;
    logic [1:0] status;
    logic [6:0] found_addr;
    logic       last;
  } bus_op_t;

  // predicted sequencer state
  logic [2:0]  seq_phase = PhIdle;
  logic        read_mode;
  logic [6:0]  dev_q;
  logic [15:0] reg_q;
  logic [1:0]  reg_left;
  logic [7:0]  data_left;
  logic [6:0]  probe;

  bus_op_t step_ops[$];
  bus_op_t bus_ops_due[$];

  assign busy = (seq_phase != PhIdle);

  task automatic emit_op(input logic [2:0] op, input logic [7:0] b_val, input logic ack,
                         input logic [1:0] st, input logic [6:0] fa);
    bus_op_t r;
    r.op         = op;
    r.bus_byte   = b_val;
    r.master_ack = ack;
    r.status     = st;
    r.found_addr = fa;
    r.last       = 1'b0;
    step_ops.push_back(r);
  endtask

  task automatic wrap_up(input logic [1:0] st);
    emit_op(OpStop, 8'h00, 1'b0, StOk, 7'd0);
    emit_op(OpDone, 8'h00, 1'b0, st, 7'd0);
    seq_phase = PhIdle;
  endtask

  // master acks every byte but the final one
  task automatic fetch_byte();
    emit_op(OpRecv, DummyByte, data_left > 8'd1, StOk, 7'd0);
    seq_phase = PhRecv;
  endtask

  task automatic advance_sequencer(input logic [1:0] mode, input logic [6:0] dev,
                                   input logic [15:0] reg_a, input logic [1:0] rlen,
                                   input logic [7:0] dlen, input logic nack,
                                   input logic [7:0] rx, input logic [7:0] pay);
    bus_op_t r;
    step_ops.delete();
    if (mode != ModeResp) begin
      // commands only start from idle
      if (seq_phase == PhIdle) begin
        if (mode == ModeScan) begin
          read_mode = 1'b0;
          probe     = 7'd1;
          emit_op(OpStart, 8'h00, 1'b0, StOk, 7'd0);
          emit_op(OpSend, {probe, 1'b0}, 1'b0, StOk, 7'd0);
          seq_phase = PhScan;
        end else begin
          read_mode = (mode == ModeRead);
          dev_q     = dev;
          reg_q     = reg_a;
          reg_left  = (rlen == 2'd2) ? 2'd2 : ((rlen != 2'd0) ? 2'd1 : 2'd0);
          data_left = dlen;
          if (read_mode && data_left == 8'd0) begin
            emit_op(OpDone, 8'h00, 1'b0, StOk, 7'd0);
          end else begin
            emit_op(OpStart, 8'h00, 1'b0, StOk, 7'd0);
            emit_op(OpSend, {dev_q, 1'b0}, 1'b0, StOk, 7'd0);
            seq_phase = PhHdr;
          end
        end
      end
    end else begin
      case (seq_phase)
        PhHdr: begin
          if (nack) begin
            wrap_up(StNack);
          end else if (reg_left == 2'd2) begin
            emit_op(OpSend, reg_q[15:8], 1'b0, StOk, 7'd0);
            reg_left = 2'd1;
          end else if (reg_left == 2'd1) begin
            emit_op(OpSend, reg_q[7:0], 1'b0, StOk, 7'd0);
            reg_left = 2'd0;
          end else if (read_mode) begin
            emit_op(OpStart, 8'h00, 1'b0, StOk, 7'd0);
            emit_op(OpSend, {dev_q, 1'b1}, 1'b0, StOk, 7'd0);
            seq_phase = PhRaddr;
          end else if (data_left == 8'd0) begin
            wrap_up(StOk);
          end else begin
            emit_op(OpSend, pay, 1'b0, StOk, 7'd0);
            data_left = data_left - 8'd1;
            seq_phase = PhWdata;
          end
        end
        PhWdata: begin
          if (nack) begin
            wrap_up(StNack);
          end else if (data_left == 8'd0) begin
            wrap_up(StOk);
          end else begin
            emit_op(OpSend, pay, 1'b0, StOk, 7'd0);
            data_left = data_left - 8'd1;
          end
        end
        PhRaddr: begin
          if (nack) wrap_up(StNack);
          else fetch_byte();
        end
        PhRecv: begin
          // nack on a received byte means nothing
          emit_op(OpOut, rx, 1'b0, StOk, 7'd0);
          if (data_left != 8'd0) data_left = data_left - 8'd1;
          if (data_left == 8'd0) wrap_up(StOk);
          else fetch_byte();
        end
        PhScan: begin
          emit_op(OpStop, 8'h00, 1'b0, StOk, 7'd0);
          if (!nack) begin
            emit_op(OpDone, 8'h00, 1'b0, StOk, probe);
            seq_phase = PhIdle;
          end else if (probe >= LastProbe) begin
            emit_op(OpDone, 8'h00, 1'b0, StNone, 7'd0);
            seq_phase = PhIdle;
          end else begin
            probe = probe + 7'd1;
            emit_op(OpStart, 8'h00, 1'b0, StOk, 7'd0);
            emit_op(OpSend, {probe, 1'b0}, 1'b0, StOk, 7'd0);
          end
        end
        default: seq_phase = PhIdle;
      endcase
    end
    foreach (step_ops[i]) begin
      r      = step_ops[i];
      r.last = (i == int'(step_ops.size()) - 1);
      bus_ops_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bus_op_t want;
    if (!rst_n) begin
      seq_phase     = PhIdle;
      read_mode     = 1'b0;
      dev_q         = 7'd0;
      reg_q         = 16'd0;
      reg_left      = 2'd0;
      data_left     = 8'd0;
      probe         = 7'd0;
      bus_ops_due.delete();
      fail_count    = 0;
      items_taken   = 0;
      beats_checked = 0;
      done_ok       = 0;
      done_nack     = 0;
      done_none     = 0;
    end else begin
      // a beat accepted here belongs to an earlier item, so check first
      if (pop && !empty) begin
        if (bus_ops_due.size() == 0) begin
          $error("result beat with nothing expected: op %0d byte %0h", out_op, out_bus_byte);
          fail_count++;
        end else begin
          want = bus_ops_due.pop_front();
          check_field("op", 8'(want.op), 8'(out_op));
          check_field("bus_byte", want.bus_byte, out_bus_byte);
          check_field("master_ack", 8'(want.master_ack), 8'(out_master_ack));
          check_field("status", 8'(want.status), 8'(out_status));
          check_field("found_addr", 8'(want.found_addr), 8'(out_found_addr));
          check_field("last", 8'(want.last), 8'(out_last));
          beats_checked++;
          if (want.op == OpDone) begin
            case (want.status)
              StOk:    done_ok++;
              StNack:  done_nack++;
              default: done_none++;
            endcase
          end
        end
      end
      if (push && !full) begin
        items_taken++;
        advance_sequencer(in_mode, in_dev_addr, in_reg_addr, in_reg_len, in_data_len,
                          in_nack, in_rx_byte, in_payload);
      end
    end
    pending = bus_ops_due.size();
  end

endmodule

### sim/tb_i2c_register_transaction_sequencer_top.sv
module tb_i2c_register_transaction_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2crs_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 80;
  localparam int RandomItems = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_mode;
  logic [6:0]  in_dev_addr;
  logic [15:0] in_reg_addr;
  logic [1:0]  in_reg_len;
  logic [7:0]  in_data_len;
  logic        in_nack;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_payload;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_op;
  logic [7:0]  out_bus_byte;
  logic        out_master_ack;
  logic [1:0]  out_status;
  logic [6:0]  out_found_addr;
  logic        out_last;

  int   fail_count;
  int   pending;
  logic busy;
  int   items_taken;
  int   beats_checked;
  int   done_ok;
  int   done_nack;
  int   done_none;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int useful_items = 0;
  int cycle_count = 0;

  i2c_register_transaction_sequencer_top u_dut (.*);

  i2c_sequencer_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout with %0d result beats outstanding", pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side; a long hold-off is counted here, not in the sender
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic put_item(input logic [1:0] mode, input logic [6:0] dev,
                          input logic [15:0] reg_a, input logic [1:0] rlen,
                          input logic [7:0] dlen, input logic nack,
                          input logic [7:0] rx, input logic [7:0] pay);
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    // busy cannot change before this beat is taken
    if ((mode == ModeResp) == busy) useful_items++;
    push        <= 1'b1;
    in_mode     <= mode;
    in_dev_addr <= dev;
    in_reg_addr <= reg_a;
    in_reg_len  <= rlen;
    in_data_len <= dlen;
    in_nack     <= nack;
    in_rx_byte  <= rx;
    in_payload  <= pay;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_resp(input logic nack);
    put_item(ModeResp, 7'($urandom_range(127)), 16'($urandom_range(65535)),
             2'($urandom_range(3)), 8'($urandom_range(255)), nack,
             8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // command, then engine responses until the sequencer goes idle
  task automatic run_transaction(input logic [1:0] mode, input logic [6:0] dev,
                                 input logic [15:0] reg_a, input logic [1:0] rlen,
                                 input logic [7:0] dlen, input int nack_pct,
                                 input int nack_at, input int noise_pct);
    int k;
    k = 0;
    put_item(mode, dev, reg_a, rlen, dlen, 1'($urandom_range(1)),
             8'($urandom_range(255)), 8'($urandom_range(255)));
    while (busy) begin
      if ($urandom_range(99) < noise_pct)
        put_item(2'($urandom_range(2)), 7'($urandom_range(127)), 16'($urandom_range(65535)),
                 2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      put_resp((k == nack_at) || ($urandom_range(99) < nack_pct));
      k++;
    end
  endtask

  task automatic random_transaction();
    int pick;
    logic [7:0] dlen;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // stray beat: may start a transaction that the next one must finish
      put_item(2'($urandom_range(3)), 7'($urandom_range(127)), 16'($urandom_range(65535)),
               2'($urandom_range(3)), 8'($urandom_range(7)), 1'($urandom_range(1)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
    end else if (pick < 27) begin
      run_transaction(ModeScan, 7'($urandom_range(127)), 16'($urandom_range(65535)),
                      2'($urandom_range(3)), 8'($urandom_range(255)), 80, -1, 5);
    end else if (pick < 60) begin
      run_transaction(ModeRead, 7'($urandom_range(127)), 16'($urandom_range(65535)),
                      2'($urandom_range(3)), 8'($urandom_range(6)), 8, -1, 5);
    end else if ($urandom_range(9) == 0) begin
      // long write, usually cut short by a nack
      dlen = 8'($urandom_range(255, 8));
      run_transaction(ModeWrite, 7'($urandom_range(127)), 16'($urandom_range(65535)),
                      2'($urandom_range(3)), dlen, 12, -1, 5);
    end else begin
      run_transaction(ModeWrite, 7'($urandom_range(127)), 16'($urandom_range(65535)),
                      2'($urandom_range(3)), 8'($urandom_range(6)), 8, -1, 5);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int goal;
    rst_n       = 1'b0;
    push        = 1'b0;
    in_mode     = ModeResp;
    in_dev_addr = 7'd0;
    in_reg_addr = 16'd0;
    in_reg_len  = 2'd0;
    in_data_len = 8'd0;
    in_nack     = 1'b0;
    in_rx_byte  = 8'd0;
    in_payload  = 8'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle_pct = 10;
    rcv_idle_pct = 30;
    put_resp(1'b0);                                                    // engine beat while idle
    run_transaction(ModeRead, 7'h7F, 16'hFFFF, 2'd2, 8'd0, 0, -1, 0);   // empty read
    run_transaction(ModeWrite, 7'h00, 16'h0000, 2'd0, 8'd0, 0, -1, 0);  // header-only write
    run_transaction(ModeWrite, 7'h55, 16'hA5C3, 2'd2, 8'd2, 0, -1, 0);
    run_transaction(ModeRead, 7'h2A, 16'h5A3C, 2'd3, 8'd3, 0, -1, 0);   // reg_len 3: low byte
    run_transaction(ModeWrite, 7'h7F, 16'hFFFF, 2'd1, 8'd3, 0, 2, 0);   // nack on data byte
    run_transaction(ModeWrite, 7'h11, 16'h1234, 2'd2, 8'd1, 0, 0, 0);   // nack on device addr
    run_transaction(ModeRead, 7'h22, 16'h00FF, 2'd1, 8'd255, 0, 2, 0);  // nack on read addr
    run_transaction(ModeRead, 7'h33, 16'hFF00, 2'd0, 8'd3, 0, 2, 50);   // nack on rx, cmds busy
    run_transaction(ModeScan, 7'h00, 16'h0000, 2'd0, 8'd0, 0, -1, 0);   // first probe answers
    run_transaction(ModeScan, 7'h7F, 16'hFFFF, 2'd3, 8'd255, 100, -1, 0); // nobody answers
    drain();

    for (int stage = 0; stage < 3; stage++) begin
      snd_idle_pct = (stage == 0) ? 23 : ((stage == 1) ? 59 : 0);
      rcv_idle_pct = (stage == 0) ? 59 : ((stage == 1) ? 23 : 0);
      if (stage != 1) hold_requests++;
      goal = useful_items + RandomItems / 3;
      while (useful_items < goal) random_transaction();
      drain();
    end

    repeat (10) @(negedge clk);
    $display("%0d input beats taken (%0d acted on), %0d result beats compared",
             items_taken, useful_items, beats_checked);
    $display("transactions closed: %0d ok, %0d on nack, %0d scans with no answer",
             done_ok, done_nack, done_none);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
